>>> rtl/iee_pkg.sv
// ============================================================================
// iee_pkg: shared types and constants of the infix expression evaluator
// Widths, character codes, controller states and datapath commands.
// ============================================================================
package iee_pkg;

    localparam int VALUE_WIDTH = 48;
    localparam int FRAC_BITS   = 16;
    localparam int DIGIT_LIMIT = 31;
    localparam int CNT_WIDTH   = 5;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
    localparam int RES_WIDTH   = PROD_WIDTH - FRAC_BITS;
    localparam int DVD_WIDTH   = 64;
    localparam int STEP_WIDTH  = 7;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] VMAX      = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VMIN      = MAG_LIMIT;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGNED = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        MOP_NONE = 2'd0,
        MOP_MUL  = 2'd1,
        MOP_DIV  = 2'd2
    } mulop_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_FINISH, S_MUL, S_DIV, S_POST, S_EMIT
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_DIGIT, CMD_SIGN, CMD_MARK, CMD_MUL_START,
        CMD_DIV_START, CMD_DIV0, CMD_TERM_LOAD, CMD_MUL_STEP, CMD_MUL_DONE,
        CMD_DIV_STEP, CMD_DIV_DONE, CMD_FOLD, CMD_FOLD_ADDOP, CMD_SET_MULOP,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic   skipping;
        logic   last;
        logic   is_digit;
        logic   is_addsub;
        logic   is_muldiv;
        logic   phase_start;
        mulop_t pend_mul;
        logic   v_zero;
        logic   closed;
        logic   count_done;
        logic   out_valid;
    } status_t;

    // Clamps a magnitude with a sign to the signed range; the top bit is the saturation flag.
    function automatic logic [VALUE_WIDTH:0] clamp(input logic [RES_WIDTH-1:0] mag,
                                                   input logic neg);
        logic [VALUE_WIDTH:0] r;
        if (neg) begin
            if (mag > RES_WIDTH'(MAG_LIMIT)) r = {1'b1, VMIN};
            else r = {1'b0, VALUE_WIDTH'(0) - mag[VALUE_WIDTH-1:0]};
        end else begin
            if (mag > RES_WIDTH'(VMAX)) r = {1'b1, VMAX};
            else r = {1'b0, mag[VALUE_WIDTH-1:0]};
        end
        return r;
    endfunction

endpackage

>>> rtl/iee_datapath.sv
// ============================================================================
// iee_datapath: operand, term and sum registers with shift-add multiply,
// restoring divide, saturating add and the output register.
// ============================================================================
module iee_datapath
    import iee_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    input  logic [7:0]             in_char,
    input  logic                   in_last,
    input  logic                   out_ready,
    output status_t                status,
    output logic [VALUE_WIDTH-1:0] out_value,
    output logic [2:0]             out_flags,
    output logic                   out_valid
);

    logic [VALUE_WIDTH-1:0] sum_reg, term_reg, opv_reg, den_reg, acc_reg, rem_reg;
    logic [DVD_WIDTH-1:0]   lo_reg;
    logic                   neg_reg, mneg_reg, addop_reg, closed_reg, skip_reg;
    logic [CNT_WIDTH-1:0]   dcnt_reg;
    mulop_t                 mop_reg;
    phase_t                 phase_reg;
    logic [2:0]             flags_reg;
    logic [7:0]             char_reg;
    logic                   last_reg;
    logic [STEP_WIDTH-1:0]  cnt_reg;
    logic [VALUE_WIDTH-1:0] oval_reg;
    logic [2:0]             oflags_reg;
    logic                   ovalid_reg;

    logic                   is_digit;
    logic [VALUE_WIDTH+3:0] dig_next;
    logic [VALUE_WIDTH:0]   v_cl;
    logic [VALUE_WIDTH-1:0] v_val, v_mag, t_mag;
    logic [VALUE_WIDTH:0]   fold_sum;
    logic [VALUE_WIDTH:0]   fold_res;
    logic [VALUE_WIDTH:0]   mul_add;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic                   rem_ge;
    logic [VALUE_WIDTH:0]   mul_cl, div_cl;

    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign dig_next = ({4'd0, opv_reg} << 3) + ({4'd0, opv_reg} << 1)
                    + ((VALUE_WIDTH+4)'(char_reg - CH_ZERO) << FRAC_BITS);

    assign v_cl  = clamp(RES_WIDTH'(opv_reg), neg_reg);
    assign v_val = v_cl[VALUE_WIDTH-1:0];
    assign v_mag = neg_reg ? opv_reg : v_val;
    assign t_mag = term_reg[VALUE_WIDTH-1] ? VALUE_WIDTH'(0) - term_reg : term_reg;

    assign fold_sum = addop_reg
        ? {sum_reg[VALUE_WIDTH-1], sum_reg} - {term_reg[VALUE_WIDTH-1], term_reg}
        : {sum_reg[VALUE_WIDTH-1], sum_reg} + {term_reg[VALUE_WIDTH-1], term_reg};
    // Overflow shows as disagreement of the two top bits; the top bit gives the direction.
    assign fold_res = (fold_sum[VALUE_WIDTH] != fold_sum[VALUE_WIDTH-1])
        ? {1'b1, (fold_sum[VALUE_WIDTH] ? VMIN : VMAX)}
        : {1'b0, fold_sum[VALUE_WIDTH-1:0]};

    assign mul_add   = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, den_reg} : '0);
    assign rem_shift = {rem_reg, lo_reg[DVD_WIDTH-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign mul_cl    = clamp(RES_WIDTH'({acc_reg, lo_reg[VALUE_WIDTH-1:0]} >> FRAC_BITS),
                             mneg_reg);
    assign div_cl    = clamp(RES_WIDTH'(lo_reg), mneg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            term_reg   <= '0;
            opv_reg    <= '0;
            neg_reg    <= 1'b0;
            dcnt_reg   <= '0;
            addop_reg  <= 1'b0;
            mop_reg    <= MOP_NONE;
            phase_reg  <= PH_START;
            flags_reg  <= '0;
            skip_reg   <= 1'b0;
            closed_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (ovalid_reg && out_ready && cmd != CMD_EMIT) ovalid_reg <= 1'b0;
            unique case (cmd)
                CMD_LOAD: begin
                    if (skip_reg) begin
                        if (in_last) skip_reg <= 1'b0;
                    end else begin
                        char_reg <= in_char;
                        last_reg <= in_last;
                    end
                end
                CMD_DIGIT: begin
                    if (dcnt_reg < CNT_WIDTH'(DIGIT_LIMIT)) begin
                        if (dig_next > (VALUE_WIDTH+4)'(MAG_LIMIT)) begin
                            opv_reg      <= MAG_LIMIT;
                            flags_reg[2] <= 1'b1;
                        end else begin
                            opv_reg <= dig_next[VALUE_WIDTH-1:0];
                        end
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                    phase_reg <= PH_DIGITS;
                end
                CMD_SIGN: begin
                    neg_reg   <= (char_reg == CH_MINUS);
                    phase_reg <= PH_SIGNED;
                end
                CMD_MARK: begin
                    closed_reg <= 1'b0;
                    if ((char_reg == CH_STAR || char_reg == CH_SLASH) && phase_reg != PH_DIGITS)
                        flags_reg[0] <= 1'b1;
                end
                CMD_MUL_START, CMD_DIV_START, CMD_DIV0, CMD_TERM_LOAD: begin
                    opv_reg   <= '0;
                    neg_reg   <= 1'b0;
                    dcnt_reg  <= '0;
                    mop_reg   <= MOP_NONE;
                    phase_reg <= PH_START;
                    if (v_cl[VALUE_WIDTH]) flags_reg[2] <= 1'b1;
                    mneg_reg <= term_reg[VALUE_WIDTH-1] ^ v_val[VALUE_WIDTH-1];
                    if (cmd == CMD_MUL_START) begin
                        den_reg <= t_mag;
                        acc_reg <= '0;
                        lo_reg  <= DVD_WIDTH'(v_mag);
                        cnt_reg <= STEP_WIDTH'(VALUE_WIDTH);
                    end else if (cmd == CMD_DIV_START) begin
                        den_reg <= v_mag;
                        rem_reg <= '0;
                        lo_reg  <= DVD_WIDTH'(t_mag) << FRAC_BITS;
                        cnt_reg <= STEP_WIDTH'(DVD_WIDTH);
                    end else if (cmd == CMD_DIV0) begin
                        term_reg     <= '0;
                        flags_reg[1] <= 1'b1;
                        closed_reg   <= 1'b1;
                    end else begin
                        term_reg <= v_val;
                    end
                end
                CMD_MUL_STEP: begin
                    acc_reg                  <= mul_add[VALUE_WIDTH:1];
                    lo_reg[VALUE_WIDTH-1:0]  <= {mul_add[0], lo_reg[VALUE_WIDTH-1:1]};
                    cnt_reg                  <= cnt_reg - 1'b1;
                end
                CMD_DIV_STEP: begin
                    rem_reg <= rem_ge ? VALUE_WIDTH'(rem_shift - {1'b0, den_reg})
                                      : rem_shift[VALUE_WIDTH-1:0];
                    lo_reg  <= {lo_reg[DVD_WIDTH-2:0], rem_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                end
                CMD_MUL_DONE: begin
                    term_reg <= mul_cl[VALUE_WIDTH-1:0];
                    if (mul_cl[VALUE_WIDTH]) flags_reg[2] <= 1'b1;
                end
                CMD_DIV_DONE: begin
                    term_reg <= div_cl[VALUE_WIDTH-1:0];
                    if (div_cl[VALUE_WIDTH]) flags_reg[2] <= 1'b1;
                end
                CMD_FOLD, CMD_FOLD_ADDOP: begin
                    sum_reg  <= fold_res[VALUE_WIDTH-1:0];
                    term_reg <= '0;
                    if (fold_res[VALUE_WIDTH]) flags_reg[2] <= 1'b1;
                    if (cmd == CMD_FOLD_ADDOP) addop_reg <= (char_reg == CH_MINUS);
                end
                CMD_SET_MULOP: begin
                    mop_reg <= (char_reg == CH_STAR) ? MOP_MUL : MOP_DIV;
                end
                CMD_EMIT: begin
                    // Present the result and clear the expression.
                    oval_reg   <= sum_reg;
                    oflags_reg <= flags_reg;
                    ovalid_reg <= 1'b1;
                    sum_reg    <= '0;
                    term_reg   <= '0;
                    addop_reg  <= 1'b0;
                    flags_reg  <= '0;
                    skip_reg   <= !last_reg;
                end
                default: begin
                end
            endcase
        end
    end

    assign status.skipping    = skip_reg;
    assign status.last        = last_reg;
    assign status.is_digit    = is_digit;
    assign status.is_addsub   = (char_reg == CH_PLUS) || (char_reg == CH_MINUS);
    assign status.is_muldiv   = (char_reg == CH_STAR) || (char_reg == CH_SLASH);
    assign status.phase_start = (phase_reg == PH_START);
    assign status.pend_mul    = mop_reg;
    assign status.v_zero      = (opv_reg == '0);
    assign status.closed      = closed_reg;
    assign status.count_done  = (cnt_reg == '0);
    assign status.out_valid   = ovalid_reg;

    assign out_value = oval_reg;
    assign out_flags = oflags_reg;
    assign out_valid = ovalid_reg;

endmodule

>>> rtl/iee_ctrl.sv
// ============================================================================
// iee_ctrl: sequencing state machine of the expression evaluator
// Decodes each character and steps the datapath through operand, term and sum.
// ============================================================================
module iee_ctrl
    import iee_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    out_ready,
    input  status_t status,
    output logic    in_ready,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   tail_reg, tail_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tail_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        tail_next  = tail_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && !status.skipping) state_next = S_DECODE;
            end
            S_DECODE: begin
                if (status.is_digit || (status.is_addsub && status.phase_start)) begin
                    state_next = status.last ? S_FINISH : S_IDLE;
                    tail_next  = 1'b1;
                end else begin
                    state_next = S_FINISH;
                    tail_next  = 1'b0;
                end
            end
            S_FINISH: begin
                if (status.pend_mul == MOP_MUL) state_next = S_MUL;
                else if (status.pend_mul == MOP_DIV && !status.v_zero) state_next = S_DIV;
                else state_next = S_POST;
            end
            S_MUL, S_DIV: begin
                if (status.count_done) state_next = S_POST;
            end
            S_POST: begin
                if (tail_reg) begin
                    state_next = S_EMIT;
                end else if (status.is_addsub || (status.is_muldiv && !status.closed)) begin
                    state_next = status.last ? S_FINISH : S_IDLE;
                    tail_next  = 1'b1;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!status.out_valid || out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = CMD_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) cmd = CMD_LOAD;
            end
            S_DECODE: begin
                if (status.is_digit) cmd = CMD_DIGIT;
                else if (status.is_addsub && status.phase_start) cmd = CMD_SIGN;
                else cmd = CMD_MARK;
            end
            S_FINISH: begin
                if (status.pend_mul == MOP_MUL) cmd = CMD_MUL_START;
                else if (status.pend_mul == MOP_DIV)
                    cmd = status.v_zero ? CMD_DIV0 : CMD_DIV_START;
                else cmd = CMD_TERM_LOAD;
            end
            S_MUL: cmd = status.count_done ? CMD_MUL_DONE : CMD_MUL_STEP;
            S_DIV: cmd = status.count_done ? CMD_DIV_DONE : CMD_DIV_STEP;
            S_POST: begin
                if (tail_reg) cmd = CMD_FOLD;
                else if (status.is_addsub) cmd = CMD_FOLD_ADDOP;
                else if (status.is_muldiv && !status.closed) cmd = CMD_SET_MULOP;
                else cmd = CMD_FOLD;
            end
            S_EMIT: begin
                // The result goes out once the output register is free.
                if (!status.out_valid || out_ready) cmd = CMD_EMIT;
            end
            default: cmd = CMD_NONE;
        endcase
    end

endmodule

>>> rtl/infix_expression_evaluator_top.sv
// ============================================================================
// infix_expression_evaluator_top: streaming infix expression evaluator
// Evaluates ASCII infix expressions in signed Q31.16 with two precedence levels.
// ============================================================================
// Characters enter on the s_ channel, one per transaction; s_tlast marks the
// final character of an expression. A character that is neither a digit nor
// an operator, or s_tlast, ends the expression and one result transaction
// leaves on the m_ channel: the saturated value in m_tdata and the invalid
// operand, divide by zero and saturated flags in m_tuser. After an early end
// the block drops characters up to and including the next s_tlast.
// A digit or sign passes through the load and decode states. An operator
// also passes through the operand finish and post states, plus the multiply
// state when it closes a multiply (one bit per cycle of the shift-add
// multiplier) or the divide state when it closes a divide (restoring divider,
// one quotient bit per cycle over a 64-bit dividend). The character with
// s_tlast may add a second operand finish. The output register holds a result
// while the receiver stalls; input continues until a second result is ready.
// Synchronous reset clears all expression state and drops a waiting result.
// ============================================================================
module infix_expression_evaluator_top
    import iee_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [47:0] value
    output logic [2:0]  m_tuser    // [0] invalid_operand, [1] divide_by_zero, [2] saturated
);

    cmd_t    cmd;
    status_t status;

    iee_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    iee_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .status    (status),
        .out_value (m_tdata),
        .out_flags (m_tuser),
        .out_valid (m_tvalid)
    );

endmodule
